[hw/rtl/sgm_pkg.sv]
// Shared types, constants and pipeline latencies of the spectral gain mask filter.
// Used by every module under hw/rtl; depends on nothing.
package sgm_pkg;

    localparam int FFT_LEN = 4096;
    localparam int IDX_W   = $clog2(FFT_LEN / 2 + 1);
    localparam int SMP_W   = 24;
    localparam int GAIN_W  = 17;

    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;

    // filter_mode codes; the unused code behaves as bandpass
    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_BAND = 2'd2;

    // register indexes of the configuration port
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SPACING = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_CUT_LO  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_CUT_HI  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DECAY   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_OFFSET  = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_POWER   = 3'd6;

    // log2 / exp2 arithmetic
    localparam int LOG_STEPS = 30;
    localparam int LOG_W     = LOG_STEPS + 6;
    localparam int EXP_TERMS = 20;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [53:0] K_LOG2E = 54'sd567758570;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int Q_AW   = 2;
    localparam int Q_CW   = 3;

    // latencies in clock enables
    localparam int LOG_LAT  = LOG_STEPS + 2;
    localparam int EXP_LAT  = 2 * (EXP_TERMS - 1) + 2;
    localparam int GAIN_LAT = LOG_LAT + 5 + EXP_LAT + 2 + EXP_LAT + 1;

    typedef struct packed {
        logic [1:0]  filter_mode;
        logic [31:0] bin_spacing;
        logic [31:0] cutoff_low;
        logic [31:0] cutoff_high;
        logic [23:0] decay_scale;
        logic [31:0] edge_offset;
        logic [31:0] sharpness_power;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]        bin_index;
        logic signed [SMP_W-1:0] sample_re;
        logic signed [SMP_W-1:0] sample_im;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_re;
        logic signed [SMP_W-1:0] out_im;
        logic [GAIN_W-1:0]       gain_value;
        logic                    config_error;
    } t_out;

    typedef struct packed {
        logic [1:0]              mode;
        logic                    err;
        logic                    pass_lo;
        logic                    pass_hi;
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } t_side;

    typedef struct packed {
        logic [31:0] x_lo;
        logic [31:0] x_hi;
        t_side       side;
    } t_job;

endpackage

[hw/rtl/sgm_queue.sv]
// Short FIFO of classified jobs between the front and the back.
// Depends on sgm_pkg.
module sgm_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  sgm_pkg::t_job             i_data,
    input  logic                      i_pop,
    output logic                      o_valid,
    output sgm_pkg::t_job             o_data,
    output logic [sgm_pkg::Q_CW-1:0]  o_count
);
    sgm_pkg::t_job             r_mem [0:sgm_pkg::QDEPTH-1];
    logic [sgm_pkg::Q_AW-1:0]  r_wp;
    logic [sgm_pkg::Q_AW-1:0]  r_rp;
    logic [sgm_pkg::Q_CW-1:0]  r_cnt;
    logic                      do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + Q_CW_ONE(i_push) - Q_CW_ONE(do_pop);
        end
    end

    function automatic logic [sgm_pkg::Q_CW-1:0] Q_CW_ONE(input logic b);
        Q_CW_ONE = {{(sgm_pkg::Q_CW-1){1'b0}}, b};
    endfunction

endmodule

[hw/rtl/sgm_front.sv]
// Front end: takes bin transactions, forms the bin frequency and the distances
// to both cutoffs, and pushes classified jobs into the queue. Depends on sgm_pkg.
module sgm_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sgm_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  sgm_pkg::t_in              i_data,
    input  logic [sgm_pkg::Q_CW-1:0]  i_q_count,
    output logic                      o_push,
    output sgm_pkg::t_job             o_job
);
    logic                                r_f1_v;
    logic [sgm_pkg::IDX_W+31:0]          r_fp;
    logic signed [sgm_pkg::SMP_W-1:0]    r_re;
    logic signed [sgm_pkg::SMP_W-1:0]    r_im;
    logic                                r_f2_v;
    sgm_pkg::t_job                       r_job;

    logic [sgm_pkg::Q_CW-1:0]  credit_used;
    logic                      accept;
    logic [31:0]               freq;
    logic [32:0]               sum_lo;
    logic [32:0]               sum_hi;
    sgm_pkg::t_job             n_job;

    // room is reserved for everything already in flight toward the queue
    assign credit_used = i_q_count + {{(sgm_pkg::Q_CW-1){1'b0}}, r_f1_v}
                         + {{(sgm_pkg::Q_CW-1){1'b0}}, r_f2_v};
    assign o_ready = (credit_used < sgm_pkg::Q_CW'(sgm_pkg::QDEPTH));
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        r_fp <= i_data.bin_index * i_cfg.bin_spacing;
        r_re <= i_data.sample_re;
        r_im <= i_data.sample_im;
    end

    always_comb begin
        freq   = (|r_fp[sgm_pkg::IDX_W+31:32]) ? 32'hFFFF_FFFF : r_fp[31:0];
        sum_lo = {1'b0, freq - i_cfg.cutoff_high} + {1'b0, i_cfg.edge_offset};
        sum_hi = {1'b0, i_cfg.cutoff_low - freq} + {1'b0, i_cfg.edge_offset};
        n_job.x_lo         = sum_lo[32] ? 32'hFFFF_FFFF : sum_lo[31:0];
        n_job.x_hi         = sum_hi[32] ? 32'hFFFF_FFFF : sum_hi[31:0];
        n_job.side.mode    = i_cfg.filter_mode;
        n_job.side.err     = (i_cfg.filter_mode != sgm_pkg::MODE_LOW)
                             && (i_cfg.filter_mode != sgm_pkg::MODE_HIGH)
                             && (i_cfg.cutoff_low >= i_cfg.cutoff_high);
        n_job.side.pass_lo = (freq <= i_cfg.cutoff_high);
        n_job.side.pass_hi = (freq >= i_cfg.cutoff_low);
        n_job.side.re      = r_re;
        n_job.side.im      = r_im;
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            r_f1_v <= accept;
            r_f2_v <= r_f1_v;
        end
    end

    assign o_push = r_f2_v;
    assign o_job  = r_job;

endmodule

[hw/rtl/sgm_log2.sv]
// Pipelined log2 of an unsigned Q16.16 value, signed Q.30 result,
// one squaring step per stage. Depends on sgm_pkg.
module sgm_log2 (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [31:0]                       i_val,
    output logic signed [sgm_pkg::LOG_W-1:0]  o_log
);
    localparam int N = sgm_pkg::LOG_STEPS;

    logic [4:0]        n_e;
    logic [4:0]        r_e0;
    logic [31:0]       r_v0;
    logic [31:0]       r_m    [0:N];
    logic [N-1:0]      r_frac [0:N];
    logic [4:0]        r_ee   [0:N];
    logic signed [5:0] exp_int;

    // leading one position
    always_comb begin
        n_e = '0;
        for (int i = 1; i < 32; i++) begin
            if (i_val[i]) begin
                n_e = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v0     <= i_val;
            r_e0     <= n_e;
            r_m[0]   <= r_v0 << (5'd31 - r_e0);
            r_frac[0] <= '0;
            r_ee[0]  <= r_e0;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] mm;
        assign sq = r_m[s] * r_m[s];
        assign mm = sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[s+1]    <= mm[32] ? mm[32:1] : mm[31:0];
                r_frac[s+1] <= {r_frac[s][N-2:0], mm[32]};
                r_ee[s+1]   <= r_ee[s];
            end
        end
    end

    assign exp_int = $signed({1'b0, r_ee[N]}) - 6'sd16;
    assign o_log   = $signed({exp_int, r_frac[N]});

endmodule

[hw/rtl/sgm_exp2.sv]
// Pipelined 2^F for a Q.32 fraction by the series of (F ln2)^k / k! for k = 0 to 20.
// Result Q.32 in [2^32, 2^33). Depends on sgm_pkg.
module sgm_exp2 (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [31:0]  i_f,
    output logic [32:0]  o_sum
);
    localparam int NT = sgm_pkg::EXP_TERMS - 1;

    logic [63:0] y_prod;
    logic [31:0] r_y  [0:NT-1];
    logic [31:0] r_t  [0:NT];
    logic [32:0] r_s  [0:NT];
    logic [31:0] r_p  [0:NT-1];
    logic [32:0] r_sp [0:NT-1];
    logic [31:0] r_yp [0:NT-1];
    logic [32:0] r_sum;

    assign y_prod = i_f * sgm_pkg::LN2_Q32;

    // first term is y itself
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0] <= y_prod[63:32];
            r_t[0] <= y_prod[63:32];
            r_s[0] <= 33'h1_0000_0000;
        end
    end

    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int KD = j + 2;
        localparam int KL = $clog2(KD);
        // floor(n / KD) == (n * KM) >> (32 + KL) for every 32-bit n
        localparam logic [33:0] KM = 34'(((64'd1 << (32 + KL)) / KD) + 64'd1);
        logic [63:0] pp;
        logic [69:0] qq;
        assign pp = r_t[j] * r_y[j];
        assign qq = 70'(r_p[j]) * 70'(KM);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j]   <= pp[63:32];
                r_sp[j]  <= r_s[j] + {1'b0, r_t[j]};
                r_yp[j]  <= r_y[j];
                r_t[j+1] <= qq[32+KL +: 32];
                r_s[j+1] <= r_sp[j];
            end
        end
        if (j < NT - 1) begin : g_ynext
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_y[j+1] <= r_yp[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= r_s[NT] + {1'b0, r_t[NT]};
        end
    end

    assign o_sum = r_sum;

endmodule

[hw/rtl/sgm_atten.sv]
// Attenuation law exp(-c * x^d) in Q1.16 for one distance x, via log2 and exp2.
// Depends on sgm_pkg, sgm_log2, sgm_exp2.
module sgm_atten (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [31:0]                       i_x,
    input  logic signed [sgm_pkg::LOG_W-1:0]  i_lc,
    input  logic [31:0]                       i_pow,
    input  logic                              i_decay_zero,
    output logic [sgm_pkg::GAIN_W-1:0]        o_gain
);
    localparam logic signed [53:0] W_BIG  = 54'sd5368709120;
    localparam logic signed [53:0] W_BIAS = 54'sd21474836480;
    localparam int EL = sgm_pkg::EXP_LAT;

    typedef struct packed {
        logic       big;
        logic       tiny;
        logic [4:0] hi;
    } t_wcls;

    typedef struct packed {
        logic       big;
        logic       tiny;
        logic [5:0] s;
    } t_ucls;

    logic signed [sgm_pkg::LOG_W-1:0] lx;
    logic signed [sgm_pkg::LOG_W-1:0] mag_full;
    logic [34:0]                      r_mag;
    logic                             r_neg1;
    logic signed [sgm_pkg::LOG_W-1:0] r_lc1;
    logic [50:0]                      r_ph;
    logic [50:0]                      r_pl;
    logic                             r_neg2;
    logic signed [sgm_pkg::LOG_W-1:0] r_lc2;
    logic [50:0]                      vm;
    logic signed [51:0]               r_v;
    logic signed [sgm_pkg::LOG_W-1:0] r_lc3;
    logic signed [53:0]               r_w;
    logic signed [53:0]               wb;
    logic [31:0]                      r_wf;
    t_wcls                            r_g5;
    t_wcls                            r_d1 [0:EL-1];
    logic [32:0]                      e1_sum;
    logic [37:0]                      u;
    logic [5:0]                       r_ui;
    logic [31:0]                      r_uf;
    t_wcls                            r_s1;
    logic [31:0]                      r_arg;
    t_ucls                            r_s2;
    t_ucls                            r_d2 [0:EL-1];
    logic [32:0]                      e2_sum;
    logic [48:0]                      rnd;
    logic [48:0]                      g_full;
    logic [sgm_pkg::GAIN_W-1:0]       g_sat;
    logic [sgm_pkg::GAIN_W-1:0]       r_gain;

    sgm_log2 u_log (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_val (i_x),
        .o_log (lx)
    );

    assign mag_full = lx[sgm_pkg::LOG_W-1] ? -lx : lx;
    assign vm = r_ph + {16'b0, r_pl[50:16]};
    assign wb = r_w + W_BIAS;

    // scale the log by d, add log2(c) and log2(log2 e), split into int/frac
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= mag_full[34:0];
            r_neg1 <= lx[sgm_pkg::LOG_W-1];
            r_lc1  <= i_lc;
            r_ph   <= i_pow[31:16] * r_mag;
            r_pl   <= i_pow[15:0] * r_mag;
            r_neg2 <= r_neg1;
            r_lc2  <= r_lc1;
            r_v    <= r_neg2 ? -$signed({1'b0, vm}) : $signed({1'b0, vm});
            r_lc3  <= r_lc2;
            r_w    <= 54'(r_v) + 54'(r_lc3) + sgm_pkg::K_LOG2E;
            r_wf     <= {wb[29:0], 2'b00};
            r_g5.big  <= (r_w >= W_BIG);
            r_g5.tiny <= (r_w < -W_BIAS);
            r_g5.hi   <= wb[34:30];
        end
    end

    sgm_exp2 u_exp_u (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_f   (r_wf),
        .o_sum (e1_sum)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1[0] <= r_g5;
            for (int i = 1; i < EL; i++) begin
                r_d1[i] <= r_d1[i-1];
            end
        end
    end

    // u = 2^W; the bias of 20 sits in hi
    always_comb begin
        if (r_d1[EL-1].hi >= 5'd20) begin
            u = {5'b0, e1_sum} << (r_d1[EL-1].hi - 5'd20);
        end else begin
            u = {5'b0, e1_sum} >> (5'd20 - r_d1[EL-1].hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ui      <= u[37:32];
            r_uf      <= u[31:0];
            r_s1      <= r_d1[EL-1];
            // 1 - frac(u); a zero fraction wraps to 0 and gives R = 2^32
            r_arg     <= 32'd0 - r_uf;
            r_s2.big  <= r_s1.big;
            r_s2.tiny <= r_s1.tiny;
            r_s2.s    <= (r_uf == 32'd0) ? r_ui : r_ui + 6'd1;
        end
    end

    sgm_exp2 u_exp_r (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_f   (r_arg),
        .o_sum (e2_sum)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2[0] <= r_s2;
            for (int i = 1; i < EL; i++) begin
                r_d2[i] <= r_d2[i-1];
            end
        end
    end

    always_comb begin
        rnd    = {16'b0, e2_sum} + (49'd1 << (7'(r_d2[EL-1].s) + 7'd15));
        g_full = rnd >> (7'(r_d2[EL-1].s) + 7'd16);
        g_sat  = (g_full > 49'(sgm_pkg::ONE_Q16)) ? sgm_pkg::ONE_Q16 : g_full[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            priority if (i_decay_zero) begin
                r_gain <= sgm_pkg::ONE_Q16;
            end else if (r_d2[EL-1].big) begin
                r_gain <= '0;
            end else if (r_d2[EL-1].tiny) begin
                r_gain <= sgm_pkg::ONE_Q16;
            end else begin
                r_gain <= g_sat;
            end
        end
    end

    assign o_gain = r_gain;

endmodule

[hw/rtl/sgm_back.sv]
// Back end: pops jobs, runs both attenuation pipelines, combines gains by mode
// and scales the sample into the output register. Depends on sgm_pkg, sgm_log2, sgm_atten.
module sgm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sgm_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  sgm_pkg::t_job  i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output sgm_pkg::t_out  o_data
);
    localparam int GL = sgm_pkg::GAIN_LAT;

    logic                                en;
    logic                                decay_zero;
    logic signed [sgm_pkg::LOG_W-1:0]    lc;
    logic [sgm_pkg::GAIN_W-1:0]          g_lo;
    logic [sgm_pkg::GAIN_W-1:0]          g_hi;
    logic [GL-1:0]                       r_vl;
    sgm_pkg::t_side                      r_sb [0:GL-1];
    sgm_pkg::t_side                      sd;
    logic [sgm_pkg::GAIN_W-1:0]          gl_eff;
    logic [sgm_pkg::GAIN_W-1:0]          gh_eff;
    logic [33:0]                         bp;
    logic [sgm_pkg::GAIN_W-1:0]          n_g;
    logic                                r_c_v;
    logic [sgm_pkg::GAIN_W-1:0]          r_c_g;
    logic                                r_c_err;
    logic signed [sgm_pkg::SMP_W-1:0]    r_c_re;
    logic signed [sgm_pkg::SMP_W-1:0]    r_c_im;
    logic signed [41:0]                  pr_re;
    logic signed [41:0]                  pr_im;
    logic                                r_out_v;
    sgm_pkg::t_out                       r_out;

    // whole back pipeline moves together; it holds while the result waits
    assign en         = !r_out_v || i_ready;
    assign o_pop      = en && i_valid;
    assign decay_zero = (i_cfg.decay_scale == 24'd0);

    sgm_log2 u_log_c (
        .i_clk (i_clk),
        .i_en  (en),
        .i_val ({8'b0, i_cfg.decay_scale}),
        .o_log (lc)
    );

    sgm_atten u_att_lo (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_x          (i_job.x_lo),
        .i_lc         (lc),
        .i_pow        (i_cfg.sharpness_power),
        .i_decay_zero (decay_zero),
        .o_gain       (g_lo)
    );

    sgm_atten u_att_hi (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_x          (i_job.x_hi),
        .i_lc         (lc),
        .i_pow        (i_cfg.sharpness_power),
        .i_decay_zero (decay_zero),
        .o_gain       (g_hi)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= i_job.side;
            for (int i = 1; i < GL; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    assign sd     = r_sb[GL-1];
    assign gl_eff = sd.pass_lo ? sgm_pkg::ONE_Q16 : g_lo;
    assign gh_eff = sd.pass_hi ? sgm_pkg::ONE_Q16 : g_hi;
    assign bp     = gl_eff * gh_eff + 34'd32768;

    always_comb begin
        unique case (sd.mode)
            sgm_pkg::MODE_LOW:  n_g = gl_eff;
            sgm_pkg::MODE_HIGH: n_g = gh_eff;
            default:            n_g = sd.err ? '0 : bp[32:16];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_g   <= n_g;
            r_c_err <= sd.err;
            r_c_re  <= sd.re;
            r_c_im  <= sd.im;
        end
    end

    // floor(sample * gain / 65536) is an arithmetic shift
    assign pr_re = r_c_re * $signed({1'b0, r_c_g});
    assign pr_im = r_c_im * $signed({1'b0, r_c_g});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.out_re       <= pr_re[39:16];
            r_out.out_im       <= pr_im[39:16];
            r_out.gain_value   <= r_c_g;
            r_out.config_error <= r_c_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl    <= '0;
            r_c_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_vl    <= {r_vl[GL-2:0], o_pop};
            r_c_v   <= r_vl[GL-1];
            r_out_v <= r_c_v;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

[hw/rtl/spectral_gain_mask_filter.sv]
// Top level of the spectral gain mask filter: configuration registers, front,
// job queue and back. Depends on sgm_pkg, sgm_front, sgm_queue, sgm_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one real-FFT
//   bin per transaction: bin index and complex 24-bit sample. Output channel
//   (o_out_valid / i_out_ready / o_out_data) returns one transaction per bin:
//   the sample scaled by the mask gain, the Q1.16 gain, and the bandpass
//   cutoff-order error flag. Results come back in input order.
//   Throughput: one bin per clock, sustained, while the receiver takes results.
//   Path: from input acceptance to the result showing valid, a bin passes two
//   front stages, one queue slot and the gain pipeline (32-step log2, two
//   40-stage exp2 series, and the scaling stages).
//   Configuration: plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); write
//   only while no bin is in flight. Unknown indexes are ignored.
//   Reset (i_rst_n low, synchronous) loads default register values and
//   empties the queue and all pipeline valid bits.
//   Receiver stall: the output register holds its result and the whole back
//   pipeline freezes; the 4-entry queue absorbs bins from the front, and
//   o_in_ready drops once the queue plus front stages would overflow.
module spectral_gain_mask_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sgm_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  sgm_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output sgm_pkg::t_out                o_out_data
);
    sgm_pkg::t_cfg              r_cfg;
    logic                       push;
    sgm_pkg::t_job              push_job;
    logic                       q_valid;
    sgm_pkg::t_job              q_job;
    logic [sgm_pkg::Q_CW-1:0]   q_count;
    logic                       pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mode     <= sgm_pkg::MODE_LOW;
            r_cfg.bin_spacing     <= 32'd65536;
            r_cfg.cutoff_low      <= 32'd65536;
            r_cfg.cutoff_high     <= 32'd131072;
            r_cfg.decay_scale     <= 24'd58982;
            r_cfg.edge_offset     <= 32'd65536;
            r_cfg.sharpness_power <= 32'd3276800;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgm_pkg::CFG_MODE:    r_cfg.filter_mode     <= i_cfg_data[1:0];
                sgm_pkg::CFG_SPACING: r_cfg.bin_spacing     <= i_cfg_data;
                sgm_pkg::CFG_CUT_LO:  r_cfg.cutoff_low      <= i_cfg_data;
                sgm_pkg::CFG_CUT_HI:  r_cfg.cutoff_high     <= i_cfg_data;
                sgm_pkg::CFG_DECAY:   r_cfg.decay_scale     <= i_cfg_data[23:0];
                sgm_pkg::CFG_OFFSET:  r_cfg.edge_offset     <= i_cfg_data;
                sgm_pkg::CFG_POWER:   r_cfg.sharpness_power <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: frequency, cutoff distances, mode classification
    sgm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (push_job)
    );

    // decouples front from back stalls
    sgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job),
        .o_count (q_count)
    );

    // back: gain pipelines, mode combine, scaling, output register
    sgm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[tb/tb_spectral_gain_mask_filter.sv]
// Self-checking testbench for spectral_gain_mask_filter: directed and random bins
// under several register settings and handshake idling profiles.
// Depends on sgm_pkg and the spectral_gain_mask_filter RTL.
`timescale 1ns / 100ps

module tb_spectral_gain_mask_filter;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, behaves as bandpass
    localparam longint Q30      = 1073741824;   // one in Q.30
    localparam longint LOG2_LOG2E = 567758570;  // log2(log2(e)) in Q.30
    localparam logic [63:0] LN2_Q32_W = 64'd2977044472;
    localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;
    localparam int DRAIN_CYCLES = 150;           // longer than the pipeline latency
    localparam int WATCHDOG_LIMIT = 3000;        // idle cycles before giving up

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [sgm_pkg::CFG_AW-1:0] i_cfg_idx;
    logic [31:0]   i_cfg_data;
    logic          i_in_valid;
    logic          o_in_ready;
    sgm_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    sgm_pkg::t_out o_out_data;

    // Local copy of the register file, updated alongside every port write
    sgm_pkg::t_cfg  regs;
    sgm_pkg::t_out  pending_bins[$];
    int    mismatches;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_off_cycles;
    int    quiet_cycles;

    spectral_gain_mask_filter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Gain predictor: fixed-point log2 / exp2 chain
    // ------------------------------------------------------------------

    // log2 of a Q16.16 value (>= 1 LSB), signed Q.30
    function automatic longint log2_q30(logic [31:0] v);
        int e;
        logic [63:0] m;
        longint frac;
        e = 31;
        while (e > 0 && !v[e]) e--;
        m = {32'd0, v} << (31 - e);
        frac = 0;
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(e) - 16) * Q30 + frac;
    endfunction

    // 2^F for a Q.32 fraction, truncated Taylor series of e^(F ln2)
    function automatic logic [63:0] exp2_q32(logic [63:0] f);
        logic [63:0] y, term, sum;
        y = (f * LN2_Q32_W) >> 32;
        term = 64'd1 << 32;
        sum = term;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * y) >> 32) / k;
            sum = sum + term;
        end
        return sum;
    endfunction

    // exp(-c * x^d) in Q1.16
    function automatic logic [16:0] rolloff(logic [31:0] x);
        longint lx, lc, v, w;
        logic [63:0] mag, dh, dl, vm, wb, wf, u, ui, uf, r, s, g;
        int wi;
        if (regs.decay_scale == 0) return sgm_pkg::ONE_Q16;
        lx = log2_q30(x);
        lc = log2_q30({8'd0, regs.decay_scale});
        mag = (lx < 0) ? 64'(-lx) : 64'(lx);
        dh = 64'(regs.sharpness_power[31:16]);
        dl = 64'(regs.sharpness_power[15:0]);
        vm = dh * mag + ((dl * mag) >> 16);
        v = (lx < 0) ? -longint'(vm) : longint'(vm);
        w = lc + v + LOG2_LOG2E;
        if (w >= 5 * Q30) return '0;                      // attenuation beyond 2^-32
        if (w < -20 * Q30) return sgm_pkg::ONE_Q16;       // attenuation too small to show
        wb = 64'(w + 20 * Q30);
        wi = int'(wb >> 30) - 20;
        wf = (wb & 64'(Q30 - 1)) << 2;
        u = exp2_q32(wf);
        if (wi >= 0) u = u << wi;
        else u = u >> (-wi);
        ui = u >> 32;
        uf = u & SAT32;
        if (uf == 0) begin
            r = 64'd1 << 32;
            s = ui;
        end else begin
            r = exp2_q32((64'd1 << 32) - uf);
            s = ui + 1;
        end
        g = (r + (64'd1 << (s + 15))) >> (s + 16);
        if (g > 64'(sgm_pkg::ONE_Q16)) g = 64'(sgm_pkg::ONE_Q16);
        return g[16:0];
    endfunction

    function automatic logic [16:0] lowpass_gain(logic [31:0] f);
        logic [63:0] x;
        if (f <= regs.cutoff_high) return sgm_pkg::ONE_Q16;
        x = 64'(f - regs.cutoff_high) + 64'(regs.edge_offset);
        if (x > SAT32) x = SAT32;
        return rolloff(x[31:0]);
    endfunction

    function automatic logic [16:0] highpass_gain(logic [31:0] f);
        logic [63:0] x;
        if (f >= regs.cutoff_low) return sgm_pkg::ONE_Q16;
        x = 64'(regs.cutoff_low - f) + 64'(regs.edge_offset);
        if (x > SAT32) x = SAT32;
        return rolloff(x[31:0]);
    endfunction

    // floor(sample * gain / 2^16), wrapped to 24 bits
    function automatic logic [23:0] apply_gain(logic signed [23:0] smp, logic [16:0] g);
        longint p;
        p = longint'(smp) * longint'({47'd0, g});
        p = p >>> 16;
        return p[23:0];
    endfunction

    function automatic sgm_pkg::t_out mask_bin(sgm_pkg::t_in b);
        sgm_pkg::t_out r;
        logic [63:0] fp, prod;
        logic [31:0] f;
        logic [16:0] g;
        fp = 64'(b.bin_index) * 64'(regs.bin_spacing);
        f = (fp > SAT32) ? 32'hFFFF_FFFF : fp[31:0];
        r.config_error = 1'b0;
        if (regs.filter_mode == sgm_pkg::MODE_LOW) begin
            g = lowpass_gain(f);
        end else if (regs.filter_mode == sgm_pkg::MODE_HIGH) begin
            g = highpass_gain(f);
        end else if (regs.cutoff_low >= regs.cutoff_high) begin
            g = '0;
            r.config_error = 1'b1;
        end else begin
            prod = 64'(highpass_gain(f)) * 64'(lowpass_gain(f));
            g = 17'((prod + 64'd32768) >> 16);
        end
        r.out_re = apply_gain(b.sample_re, g);
        r.out_im = apply_gain(b.sample_im, g);
        r.gain_value = g;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict at input transaction, check at output transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sgm_pkg::t_out want;
        if (i_rst_n && i_in_valid && o_in_ready)
            pending_bins = {pending_bins, mask_bin(i_in_data)};
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, o_out_data);
                mismatches++;
            end else begin
                want = pending_bins.pop_front();
                if (o_out_data.out_re !== want.out_re) begin
                    $display("%0t: out_re exp %0d got %0d", $realtime,
                             want.out_re, o_out_data.out_re);
                    mismatches++;
                end
                if (o_out_data.out_im !== want.out_im) begin
                    $display("%0t: out_im exp %0d got %0d", $realtime,
                             want.out_im, o_out_data.out_im);
                    mismatches++;
                end
                if (o_out_data.gain_value !== want.gain_value) begin
                    $display("%0t: gain_value exp %0d got %0d", $realtime,
                             want.gain_value, o_out_data.gain_value);
                    mismatches++;
                end
                if (o_out_data.config_error !== want.config_error) begin
                    $display("%0t: config_error exp %0b got %0b", $realtime,
                             want.config_error, o_out_data.config_error);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_spectral_gain_mask_filter: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (called at a falling edge)
    // ------------------------------------------------------------------
    task automatic write_reg(logic [sgm_pkg::CFG_AW-1:0] idx, logic [31:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            sgm_pkg::CFG_MODE:    regs.filter_mode = data[1:0];
            sgm_pkg::CFG_SPACING: regs.bin_spacing = data;
            sgm_pkg::CFG_CUT_LO:  regs.cutoff_low = data;
            sgm_pkg::CFG_CUT_HI:  regs.cutoff_high = data;
            sgm_pkg::CFG_DECAY:   regs.decay_scale = data[23:0];
            sgm_pkg::CFG_OFFSET:  regs.edge_offset = data;
            sgm_pkg::CFG_POWER:   regs.sharpness_power = data;
            default: ;
        endcase
    endtask

    task automatic load_regs(logic [1:0] mode, logic [31:0] spacing, logic [31:0] lo,
                             logic [31:0] hi, logic [23:0] decay, logic [31:0] offs,
                             logic [31:0] power);
        write_reg(sgm_pkg::CFG_MODE, {30'd0, mode});
        write_reg(sgm_pkg::CFG_SPACING, spacing);
        write_reg(sgm_pkg::CFG_CUT_LO, lo);
        write_reg(sgm_pkg::CFG_CUT_HI, hi);
        write_reg(sgm_pkg::CFG_DECAY, {8'd0, decay});
        write_reg(sgm_pkg::CFG_OFFSET, offs);
        write_reg(sgm_pkg::CFG_POWER, power);
    endtask

    // One input transaction; valid stays high across back-to-back items
    task automatic send_bin(logic [11:0] idx, logic [23:0] re, logic [23:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data.bin_index = idx;
        i_in_data.sample_re = re;
        i_in_data.sample_im = im;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_bin();
        send_bin(12'($urandom), 24'($urandom), 24'($urandom));
    endtask

    // Sender pauses until every expected result is back, then the pipe settles
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_bins.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults, sample and index extremes, every mode and corner
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_bin(12'd0, 24'h7FFFFF, 24'h800000);
        send_bin(12'd3, 24'h800000, 24'h7FFFFF);
        send_bin(12'd2048, 24'hFFFFFF, 24'h000001);
        send_bin(12'd4095, 24'h7FFFFF, 24'hFFFFFF);   // index past half length
        drain();
        // highpass, steep roll-off near the cutoff
        load_regs(sgm_pkg::MODE_HIGH, 32'h0001_0000, 32'h0040_0000, 32'h0080_0000,
                  24'h00E666, 32'h0000_0001, 32'h0004_0000);
        send_bin(12'd0, 24'h7FFFFF, 24'h800000);
        send_bin(12'd63, 24'h123456, 24'hEDCBA9);
        send_bin(12'd64, 24'h7FFFFF, 24'h800000);
        drain();
        // bandpass in order, then mode 3 alias
        load_regs(sgm_pkg::MODE_BAND, 32'h0001_0000, 32'h0010_0000, 32'h0020_0000,
                  24'h001000, 32'h0001_0000, 32'h0001_8000);
        send_bin(12'd8, 24'h400000, 24'hC00000);
        send_bin(12'd24, 24'h7FFFFF, 24'h800000);
        send_bin(12'd40, 24'h7FFFFF, 24'h800000);
        drain();
        write_reg(sgm_pkg::CFG_MODE, {30'd0, MODE_SPARE});
        send_bin(12'd12, 24'h7FFFFF, 24'h800000);
        drain();
        // bandpass with equal cutoffs flags the error
        load_regs(sgm_pkg::MODE_BAND, 32'h0001_0000, 32'h0020_0000, 32'h0020_0000,
                  24'h001000, 32'h0001_0000, 32'h0001_0000);
        send_bin(12'd5, 24'h7FFFFF, 24'h800000);
        drain();
        // zero scale: unity beyond the cutoff; frequency saturation
        load_regs(sgm_pkg::MODE_LOW, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                  24'h000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bin(12'd1, 24'h7FFFFF, 24'h800000);
        send_bin(12'd4095, 24'h654321, 24'h9ABCDE);
        drain();
        // zero exponent: gain exp(-c) everywhere past the cutoff
        load_regs(sgm_pkg::MODE_LOW, 32'h0001_0000, 32'h0000_0001, 32'h0001_0000,
                  24'h008000, 32'h0000_0000, 32'h0000_0000);
        send_bin(12'd2, 24'h7FFFFF, 24'h800000);
        drain();
        // huge attenuation: largest scale and exponent
        load_regs(sgm_pkg::MODE_LOW, 32'h0001_0000, 32'h0000_0001, 32'h0000_0001,
                  24'hFFFFFF, 32'h0001_0000, 32'hFFFF_FFFF);
        send_bin(12'd100, 24'h7FFFFF, 24'h800000);
        drain();
        // tiny attenuation: distances well below one with a large exponent
        load_regs(sgm_pkg::MODE_LOW, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                  24'h000001, 32'h0000_0000, 32'h0010_0000);
        send_bin(12'd2, 24'h7FFFFF, 24'h800000);
        send_bin(12'd300, 24'h7FFFFF, 24'h800000);
        drain();
    endtask

    // Random register set, biased so cutoffs fall inside the bin range
    task automatic random_regs();
        logic [31:0] spacing, lo, hi, power;
        spacing = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0004_0000, 1);
        lo = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0800_0000, 1);
        hi = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0C00_0000, 1);
        power = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h0008_0000);
        load_regs(2'($urandom), spacing, lo, hi, 24'($urandom),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000),
                  power);
    endtask

    // Random bins across idling profiles, new registers each stretch
    task automatic test_random_traffic();
        int send_pct[4] = '{0, 80, 0, 37};
        int recv_pct[4] = '{0, 0, 80, 37};
        for (int p = 0; p < 4; p++) begin
            for (int c = 0; c < 3; c++) begin
                random_regs();
                send_idle_pct = send_pct[p];
                recv_stall_pct = recv_pct[p];
                repeat (35) send_random_bin();
                drain();
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering more bins than the
    // pipeline and queue can hold: input must stall
    task automatic test_backpressure();
        random_regs();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 400;
        repeat (160) send_random_bin();
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        regs = '{filter_mode: sgm_pkg::MODE_LOW, bin_spacing: 32'd65536,
                 cutoff_low: 32'd65536,
                 cutoff_high: 32'd131072, decay_scale: 24'd58982,
                 edge_offset: 32'd65536, sharpness_power: 32'd3276800};
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_traffic();
        test_backpressure();

        if (mismatches == 0 && pending_bins.size() == 0) begin
            $display("tb_spectral_gain_mask_filter: PASS");
        end else begin
            $display("tb_spectral_gain_mask_filter: FAIL");
        end
        $finish;
    end

endmodule
